// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the interval boundary lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define IBL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define IBL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ibl_pkg.sv =====
// Package with widths, command codes and constants of the interval boundary lookup.
package ibl_pkg;
   localparam int CMD_W   = 2;
   localparam int LEVEL_W = 4;
   localparam int OP_W    = 3;
   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 33;

   localparam int DEF_LEVELS = 16;
   localparam int DEF_OPS    = 8;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   localparam logic signed [DATA_W-1:0] UNSET_MARK = 32'sh7fff_ffff;
endpackage

// ===== hdl/ibl_if.sv =====
// Valid/ready channel interfaces for the command and result beats.
interface ibl_req_if import ibl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [LEVEL_W-1:0]       level;
   logic [OP_W-1:0]          first_op;
   logic [OP_W-1:0]          last_op;
   logic signed [DATA_W-1:0] data_value;

   modport source (output valid, command, level, first_op, last_op, data_value,
                   input ready);
   modport sink   (input valid, command, level, first_op, last_op, data_value,
                   output ready);
endinterface

interface ibl_rsp_if import ibl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] start_point;
   logic signed [DATA_W-1:0] end_point;
   logic signed [SIZE_W-1:0] interval_size;
   logic                     found;
   logic [LEVEL_W-1:0]       level_out;
   logic [OP_W-1:0]          op_out;

   modport source (output valid, start_point, end_point, interval_size, found,
                   level_out, op_out, input ready);
   modport sink   (input valid, start_point, end_point, interval_size, found,
                   level_out, op_out, output ready);
endinterface

// ===== hdl/interval_boundary_lookup_core.sv =====
// Interval boundary table with write, fill, interval read and binary-search lookup.
// A fill writes the first min((level+1)*OPS, depth) entries; a lookup takes at most
// log2(depth) search steps, each a search state and an evaluation state.
// One beat in flight; the next command is taken in the cycle after its result loads, and a
// held result stalls the block. Reset clears the per-entry valid bits: unwritten entries
// read as the unset mark, entry zero as zero. No clearing pass.
`include "assert_macros.svh"

module interval_boundary_lookup_core import ibl_pkg::*; #(
   parameter int LEVELS = DEF_LEVELS,
   parameter int OPS    = DEF_OPS
) (
   input  logic      clock,
   input  logic      reset,
   ibl_req_if.sink   req_chan,
   ibl_rsp_if.source rsp_chan
);
   localparam int DEPTH  = LEVELS * OPS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW     = AW + 2;
   localparam int FW     = $clog2(16 * OPS + 9);
   localparam int DIV_SH = AW + $clog2(OPS);
   localparam logic [AW:0] DIV_MUL = (AW+1)'((2 ** DIV_SH + OPS - 1) / OPS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FILL  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_REVAL = 3'd3;
   localparam logic [2:0] S_SRCH  = 3'd4;
   localparam logic [2:0] S_SEVAL = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [DATA_W-1:0] table_mem [DEPTH];
   logic [DEPTH-1:0]  entry_valid_ff;

   logic [2:0]               state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic [AW-1:0]            addr0_ff, addr0_in, addr1_ff, addr1_in;
   logic                     oob0_ff, oob0_in, oob1_ff, oob1_in;
   logic [AW-1:0]            fill_idx_ff, fill_idx_in, fill_last_ff, fill_last_in;
   logic signed [SW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]            div_q_ff, div_q_in;

   logic signed [DATA_W-1:0] res_start_ff, res_start_in, res_end_ff, res_end_in;
   logic signed [SIZE_W-1:0] res_size_ff, res_size_in;
   logic                     res_found_ff, res_found_in;
   logic [LEVEL_W-1:0]       res_level_ff, res_level_in;
   logic [OP_W-1:0]          res_op_ff, res_op_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_start_ff, rsp_end_ff;
   logic signed [SIZE_W-1:0] rsp_size_ff;
   logic                     rsp_found_ff;
   logic [LEVEL_W-1:0]       rsp_level_ff;
   logic [OP_W-1:0]          rsp_op_ff;

   logic [DATA_W-1:0] rd0_data_ff, rd1_data_ff;
   logic              rd0_valid_ff, rd1_valid_ff, rd0_zero_ff, rd1_zero_ff;

   logic                     accept, rsp_load;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr, rd0_addr, rd1_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [FW-1:0]            flat0, flat1;
   logic [31:0]              fill_cnt;
   logic signed [SW-1:0]     mid_s;
   logic signed [DATA_W-1:0] lower, upper;
   logic [2*AW:0]            div_prod;
   logic [AW-1:0]            div_quot;
   logic [AW-1:0]            div_remainder;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.start_point   = rsp_start_ff;
   assign rsp_chan.end_point     = rsp_end_ff;
   assign rsp_chan.interval_size = rsp_size_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.level_out     = rsp_level_ff;
   assign rsp_chan.op_out        = rsp_op_ff;

   assign flat0 = FW'(req_chan.level) * FW'(OPS) + FW'(req_chan.first_op);
   assign flat1 = FW'(req_chan.level) * FW'(OPS) + FW'(req_chan.last_op) + FW'(1);
   assign fill_cnt = (32'(req_chan.level) + 32'd1) * 32'(OPS);

   assign mid_s = lo_ff + ((hi_ff - lo_ff) >>> 1);

   assign lower = rd0_valid_ff ? $signed(rd0_data_ff) : (rd0_zero_ff ? '0 : UNSET_MARK);
   assign upper = rd1_valid_ff ? $signed(rd1_data_ff) : (rd1_zero_ff ? '0 : UNSET_MARK);

   // flat index split into level and slot by reciprocal multiplication
   assign div_prod      = (2*AW+1)'(div_q_ff) * (2*AW+1)'(DIV_MUL);
   assign div_quot      = AW'(div_prod >> DIV_SH);
   assign div_remainder = div_q_ff - AW'(div_quot * AW'(OPS));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = fill_idx_ff;
      wr_data = data_ff;
      if (accept && (req_chan.command == CMD_WRITE) && (32'(flat0) < 32'(DEPTH))) begin
         wr_en   = 1'b1;
         wr_addr = flat0[AW-1:0];
         wr_data = req_chan.data_value;
      end else if (state_ff == S_FILL) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      rd0_addr = addr0_ff;
      rd1_addr = addr1_ff;
      if (state_ff == S_SRCH) begin
         rd0_addr = mid_s[AW-1:0];
         rd1_addr = mid_s[AW-1:0] + AW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      addr0_in     = addr0_ff;
      addr1_in     = addr1_ff;
      oob0_in      = oob0_ff;
      oob1_in      = oob1_ff;
      fill_idx_in  = fill_idx_ff;
      fill_last_in = fill_last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      div_q_in     = div_q_ff;
      res_start_in = res_start_ff;
      res_end_in   = res_end_ff;
      res_size_in  = res_size_ff;
      res_found_in = res_found_ff;
      res_level_in = res_level_ff;
      res_op_in    = res_op_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in       = req_chan.command;
               data_in      = req_chan.data_value;
               oob0_in      = !(32'(flat0) < 32'(DEPTH));
               oob1_in      = !(32'(flat1) < 32'(DEPTH));
               addr0_in     = flat0[AW-1:0];
               addr1_in     = flat1[AW-1:0];
               fill_idx_in  = '0;
               fill_last_in = (fill_cnt > 32'(DEPTH)) ? AW'(DEPTH - 1)
                                                      : AW'(fill_cnt - 32'd1);
               lo_in        = '0;
               hi_in        = SW'(DEPTH) - SW'(2);
               res_start_in = '0;
               res_end_in   = '0;
               res_size_in  = '0;
               res_found_in = 1'b0;
               res_level_in = '0;
               res_op_in    = '0;
               case (req_chan.command)
                  CMD_WRITE: state_in = S_DONE;
                  CMD_FILL:  state_in = S_FILL;
                  CMD_READ:  state_in = S_RD;
                  default:   state_in = S_SRCH;
               endcase
            end
         end
         S_FILL: begin
            fill_idx_in = fill_idx_ff + AW'(1);
            if (fill_idx_ff == fill_last_ff) begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            state_in = S_REVAL;
         end
         S_REVAL: begin
            res_start_in = oob0_ff ? UNSET_MARK : lower;
            res_end_in   = oob1_ff ? UNSET_MARK : upper;
            res_size_in  = {res_end_in[DATA_W-1], res_end_in}
                         - {res_start_in[DATA_W-1], res_start_in};
            state_in     = S_DONE;
         end
         S_SRCH: begin
            if (lo_ff > hi_ff) begin
               state_in = S_DONE;
            end else begin
               div_q_in = mid_s[AW-1:0];
               state_in = S_SEVAL;
            end
         end
         S_SEVAL: begin
            if ((lower <= data_ff) && (data_ff < upper)) begin
               state_in = S_DIV;
            end else begin
               if ((lower == UNSET_MARK) || (lower > data_ff)) begin
                  hi_in = $signed({2'b00, div_q_ff}) - SW'(1);
               end else begin
                  lo_in = $signed({2'b00, div_q_ff}) + SW'(1);
               end
               state_in = S_SRCH;
            end
         end
         S_DIV: begin
            res_found_in = 1'b1;
            res_level_in = LEVEL_W'(div_quot);
            res_op_in    = OP_W'(div_remainder);
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      data_ff      <= data_in;
      addr0_ff     <= addr0_in;
      addr1_ff     <= addr1_in;
      oob0_ff      <= oob0_in;
      oob1_ff      <= oob1_in;
      fill_idx_ff  <= fill_idx_in;
      fill_last_ff <= fill_last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      div_q_ff     <= div_q_in;
      res_start_ff <= res_start_in;
      res_end_ff   <= res_end_in;
      res_size_ff  <= res_size_in;
      res_found_ff <= res_found_in;
      res_level_ff <= res_level_in;
      res_op_ff    <= res_op_in;
      if (rsp_load) begin
         rsp_start_ff <= res_start_ff;
         rsp_end_ff   <= res_end_ff;
         rsp_size_ff  <= res_size_ff;
         rsp_found_ff <= res_found_ff;
         rsp_level_ff <= res_level_ff;
         rsp_op_ff    <= res_op_ff;
      end
   end

   // table storage: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd0_data_ff <= table_mem[rd0_addr];
      rd1_data_ff <= table_mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // valid and zero flags are registered alongside the read data, from the same read address
   always_ff @(posedge clock) begin
      rd0_valid_ff <= entry_valid_ff[rd0_addr] && !(wr_en && (wr_addr == rd0_addr));
      rd1_valid_ff <= entry_valid_ff[rd1_addr] && !(wr_en && (wr_addr == rd1_addr));
      rd0_zero_ff  <= (rd0_addr == '0);
      rd1_zero_ff  <= (rd1_addr == '0);
   end

   `IBL_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != S_IDLE, "accepted beat not taken")
   `IBL_ASSERT_NEXT(a_done_holds, (state_ff == S_DONE) && rsp_valid_ff && !rsp_chan.ready, state_ff == S_DONE, "result dropped while output busy")
   `IBL_ASSERT(a_search_bounds, (state_ff == S_SEVAL) |-> (lo_ff <= hi_ff), "search step outside bounds")
   `IBL_ASSERT(a_found_only_lookup, ((state_ff == S_DONE) && res_found_ff) |-> (cmd_ff == CMD_LOOKUP), "found set on non-lookup")
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the interval boundary table: command stream, predictor, checker.
`timescale 1ns / 1ps

module tb_top;
   import ibl_pkg::*;

   localparam int DEPTH     = DEF_LEVELS * DEF_OPS;
   localparam int SET_ITEMS = 1275;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [LEVEL_W-1:0]       level;
      logic [OP_W-1:0]          first_op;
      logic [OP_W-1:0]          last_op;
      logic signed [DATA_W-1:0] data_value;
   } command_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] start_point;
      logic signed [DATA_W-1:0] end_point;
      logic signed [SIZE_W-1:0] interval_size;
      logic                     found;
      logic [LEVEL_W-1:0]       level_out;
      logic [OP_W-1:0]          op_out;
   } result_type;

   class boundary_scoreboard;
      logic signed [DATA_W-1:0] entries [DEPTH];
      result_type               expected_q [$];
      int                       mismatches;

      function new();
         for (int i = 0; i < DEPTH; i++) entries[i] = UNSET_MARK;
         entries[0] = '0;
         mismatches = 0;
      endfunction

      function logic signed [DATA_W-1:0] fetch(int flat);
         return (flat < DEPTH) ? entries[flat] : UNSET_MARK;
      endfunction

      function int locate(logic signed [DATA_W-1:0] key);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = DEPTH - 2;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (entries[mid] <= key && key < entries[mid+1]) return mid;
            if (entries[mid] == UNSET_MARK || entries[mid] > key) hi = mid - 1;
            else lo = mid + 1;
         end
         return -1;
      endfunction

      function void note_command(command_type c);
         result_type               r;
         int                       base;
         int                       count;
         int                       hit;
         logic signed [DATA_W-1:0] s;
         logic signed [DATA_W-1:0] e;
         r = '0;
         base = int'(c.level) * DEF_OPS;
         case (c.command)
            CMD_WRITE: begin
               if (base + int'(c.first_op) < DEPTH) entries[base + int'(c.first_op)] = c.data_value;
            end
            CMD_FILL: begin
               count = base + DEF_OPS;
               if (count > DEPTH) count = DEPTH;
               for (int i = 0; i < count; i++) entries[i] = c.data_value;
            end
            CMD_READ: begin
               s = fetch(base + int'(c.first_op));
               e = fetch(base + int'(c.last_op) + 1);
               r.start_point   = s;
               r.end_point     = e;
               r.interval_size = SIZE_W'(longint'(e) - longint'(s));
            end
            CMD_LOOKUP: begin
               hit = locate(c.data_value);
               if (hit >= 0) begin
                  r.found     = 1'b1;
                  r.level_out = LEVEL_W'(hit / DEF_OPS);
                  r.op_out    = OP_W'(hit % DEF_OPS);
               end
            end
         endcase
         expected_q.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result beat with nothing outstanding: start=%0d end=%0d",
                                           got.start_point, got.end_point);
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch exp: start=%0d end=%0d size=%0d found=%0b level=%0d op=%0d",
                        want.start_point, want.end_point, want.interval_size, want.found,
                        want.level_out, want.op_out);
               $display("         got: start=%0d end=%0d size=%0d found=%0b level=%0d op=%0d",
                        got.start_point, got.end_point, got.interval_size, got.found,
                        got.level_out, got.op_out);
            end
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ibl_req_if req ();
   ibl_rsp_if rsp ();

   interval_boundary_lookup_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #4 clock = ~clock;

   boundary_scoreboard sb = new();
   int  items_sent = 0;
   bit  send_calm  = 1'b0;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_command(logic [CMD_W-1:0] cmd, logic [LEVEL_W-1:0] lvl,
                                logic [OP_W-1:0] fa, logic [OP_W-1:0] fb,
                                logic signed [DATA_W-1:0] data);
      int          gap;
      command_type c;
      gap = send_calm ? 0 : idle_len();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      c = '{command: cmd, level: lvl, first_op: fa, last_op: fb, data_value: data};
      req.valid      <= 1'b1;
      req.command    <= cmd;
      req.level      <= lvl;
      req.first_op   <= fa;
      req.last_op    <= fb;
      req.data_value <= data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_command(c);
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // ascending boundaries (at times two swapped) written to a table prefix, then lookups
   task automatic run_sorted_group();
      longint vals [DEPTH];
      longint cur;
      longint key;
      longint span;
      int     k;
      int     stepmax;
      int     n;
      int     idx;
      int     j;
      int     a;
      int     b;
      bit     down;
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(40, DEPTH) : $urandom_range(1, 20);
      stepmax = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 1 << 24);
      cur = longint'($signed($urandom));
      if ($urandom_range(0, 5) == 0) cur = -(64'sd1 <<< 31);
      if (cur + longint'(k) * stepmax >= 64'sd2147483647)
         cur = 64'sd2147483647 - longint'(k) * stepmax - 1;
      for (int i = 0; i < k; i++) begin
         vals[i] = cur;
         cur += $urandom_range(1, stepmax);
      end
      if (k > 2 && $urandom_range(0, 5) == 0) begin
         a = $urandom_range(0, k - 1);
         b = $urandom_range(0, k - 1);
         cur = vals[a];
         vals[a] = vals[b];
         vals[b] = cur;
      end
      if ($urandom_range(0, 4) == 0) issue_command(CMD_FILL, 4'd15, 3'($urandom), 3'($urandom),
                                                   $urandom);
      else issue_command(CMD_FILL, 4'd15, 3'($urandom), 3'($urandom), UNSET_MARK);
      down = $urandom_range(0, 1);
      for (int i = 0; i < k; i++) begin
         j = down ? k - 1 - i : i;
         issue_command(CMD_WRITE, LEVEL_W'(j / DEF_OPS), OP_W'(j % DEF_OPS), 3'($urandom),
                       DATA_W'(vals[j]));
      end
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
         idx = $urandom_range(0, k - 1);
         case ($urandom_range(0, 5))
            0: key = vals[idx];
            1: key = vals[idx] - 1;
            2: begin
               if (idx < k - 1 && vals[idx+1] > vals[idx]) begin
                  span = vals[idx+1] - vals[idx];
                  key = vals[idx] + longint'($urandom) % span;
               end else begin
                  key = vals[idx] + $urandom_range(0, 3);
                  if (key > 64'sd2147483647) key = 64'sd2147483647;
               end
            end
            3: key = longint'($signed($urandom));
            default: key = vals[idx] + $urandom_range(0, stepmax);
         endcase
         if ($urandom_range(0, 5) == 0)
            issue_command(CMD_READ, 4'($urandom), 3'($urandom), 3'($urandom), $urandom);
         else
            issue_command(CMD_LOOKUP, 4'($urandom), 3'($urandom), 3'($urandom), DATA_W'(key));
      end
   endtask

   task automatic run_noise_group();
      int n;
      n = $urandom_range(4, 15);
      for (int i = 0; i < n; i++)
         issue_command(2'($urandom), 4'($urandom), 3'($urandom), 3'($urandom), $urandom);
   endtask

   initial begin : result_sink
      result_type got;
      int         stall;
      int         cyc;
      bit         calm;
      rsp.ready <= 1'b0;
      stall = 0;
      cyc   = 0;
      calm  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got.start_point   = rsp.start_point;
            got.end_point     = rsp.end_point;
            got.interval_size = rsp.interval_size;
            got.found         = rsp.found;
            got.level_out     = rsp.level_out;
            got.op_out        = rsp.op_out;
            sb.check_result(got);
         end
         cyc++;
         if (cyc % 256 == 0) calm = ($urandom_range(0, 3) == 0);
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (!calm) stall = idle_len();
         end
      end
   end

   initial begin : stimulus
      req.valid      <= 1'b0;
      req.command    <= CMD_WRITE;
      req.level      <= '0;
      req.first_op   <= '0;
      req.last_op    <= '0;
      req.data_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, extremes, past-end reads, misses, fills
      issue_command(CMD_READ,   4'd0,  3'd0, 3'd0, 32'sd0);
      issue_command(CMD_READ,   4'd15, 3'd7, 3'd7, 32'sd0);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, 32'sd0);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, -32'sd1);
      issue_command(CMD_LOOKUP, 4'd15, 3'd7, 3'd7, UNSET_MARK);
      issue_command(CMD_WRITE,  4'd0,  3'd1, 3'd0, 32'sd100);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, 32'sd100);
      issue_command(CMD_WRITE,  4'd0,  3'd0, 3'd7, UNSET_MARK);
      issue_command(CMD_WRITE,  4'd0,  3'd1, 3'd0, 32'sh8000_0000);
      issue_command(CMD_READ,   4'd0,  3'd0, 3'd0, 32'sd0);
      issue_command(CMD_WRITE,  4'd15, 3'd7, 3'd7, 32'sh8000_0000);
      issue_command(CMD_READ,   4'd15, 3'd7, 3'd7, 32'sd0);
      issue_command(CMD_READ,   4'd3,  3'd5, 3'd1, -32'sd1);
      issue_command(CMD_FILL,   4'd0,  3'd0, 3'd0, -32'sd7);
      issue_command(CMD_READ,   4'd0,  3'd0, 3'd7, 32'sd0);
      issue_command(CMD_FILL,   4'd15, 3'd7, 3'd7, 32'sd0);
      issue_command(CMD_WRITE,  4'd15, 3'd7, 3'd0, 32'sd50);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, 32'sd10);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, 32'sd50);
      issue_command(CMD_FILL,   4'd7,  3'd0, 3'd0, 32'sh8000_0000);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, 32'sh8000_0000);
      issue_command(CMD_FILL,   4'd15, 3'd0, 3'd0, UNSET_MARK);
      issue_command(CMD_LOOKUP, 4'd0,  3'd0, 3'd0, -32'sd5);
      issue_command(CMD_WRITE,  4'd10, 3'd3, 3'd7, -32'sd1);
      issue_command(CMD_READ,   4'd10, 3'd3, 3'd2, 32'sd0);
      wait_for_drain();

      while (items_sent < SET_ITEMS) begin
         send_calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            6, 7: run_noise_group();
            9: begin
               wait_for_drain();
               run_sorted_group();
            end
            default: run_sorted_group();
         endcase
      end

      wait_for_drain();
      repeat (150) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
